>>> rtl/sm4_cipher_ecb_cbc_ctr_defines.svh
`ifndef SM4_CIPHER_ECB_CBC_CTR_DEFINES_SVH
`define SM4_CIPHER_ECB_CBC_CTR_DEFINES_SVH

// checked only outside reset
`define SM4_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// checked on every edge, reset included
`define SM4_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

>>> rtl/sm4_pkg.sv
package sm4_pkg;

	localparam int ROUNDS = 32;
	localparam int RK_AW = $clog2(ROUNDS);
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IV_HIGH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IV_LOW   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd4;

	typedef enum logic [2:0] {
		MODE_ECB_ENC = 3'd0,
		MODE_ECB_DEC = 3'd1,
		MODE_CBC_ENC = 3'd2,
		MODE_CBC_DEC = 3'd3,
		MODE_CTR     = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXPAND,
		ST_PREP,
		ST_ROUND,
		ST_FINISH
	} sm4_state_t;

	localparam logic [31:0] FK0 = 32'hA3B1BAC6;
	localparam logic [31:0] FK1 = 32'h56AA3350;
	localparam logic [31:0] FK2 = 32'h677D9197;
	localparam logic [31:0] FK3 = 32'hB27022DC;
	localparam logic [31:0] CK_INIT = 32'h00040C14;
	localparam logic [31:0] CK_XOR  = 32'h00030201;
	localparam logic [31:0] CK_STEP = 32'h1C1C1C1C;
	localparam logic [31:0] CK_MASK = 32'hFCFCFCFC;

	typedef struct packed {
		logic        first;
		logic [63:0] data_high;
		logic [63:0] data_low;
	} in_item_t;

	typedef struct packed {
		logic [63:0] result_high;
		logic [63:0] result_low;
	} out_item_t;

	typedef struct packed {
		logic [63:0] key_high;
		logic [63:0] key_low;
		logic [63:0] iv_high;
		logic [63:0] iv_low;
		logic [2:0]  mode;
		logic        key_wr;
	} cfg_regs_t;

	typedef struct packed {
		logic             we;
		logic [RK_AW-1:0] waddr;
		logic [31:0]      wdata;
		logic [RK_AW-1:0] raddr;
	} rk_req_t;

	localparam logic [7:0] SBOX [256] = '{
		8'hD6, 8'h90, 8'hE9, 8'hFE, 8'hCC, 8'hE1, 8'h3D, 8'hB7,
		8'h16, 8'hB6, 8'h14, 8'hC2, 8'h28, 8'hFB, 8'h2C, 8'h05,
		8'h2B, 8'h67, 8'h9A, 8'h76, 8'h2A, 8'hBE, 8'h04, 8'hC3,
		8'hAA, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
		8'h9C, 8'h42, 8'h50, 8'hF4, 8'h91, 8'hEF, 8'h98, 8'h7A,
		8'h33, 8'h54, 8'h0B, 8'h43, 8'hED, 8'hCF, 8'hAC, 8'h62,
		8'hE4, 8'hB3, 8'h1C, 8'hA9, 8'hC9, 8'h08, 8'hE8, 8'h95,
		8'h80, 8'hDF, 8'h94, 8'hFA, 8'h75, 8'h8F, 8'h3F, 8'hA6,
		8'h47, 8'h07, 8'hA7, 8'hFC, 8'hF3, 8'h73, 8'h17, 8'hBA,
		8'h83, 8'h59, 8'h3C, 8'h19, 8'hE6, 8'h85, 8'h4F, 8'hA8,
		8'h68, 8'h6B, 8'h81, 8'hB2, 8'h71, 8'h64, 8'hDA, 8'h8B,
		8'hF8, 8'hEB, 8'h0F, 8'h4B, 8'h70, 8'h56, 8'h9D, 8'h35,
		8'h1E, 8'h24, 8'h0E, 8'h5E, 8'h63, 8'h58, 8'hD1, 8'hA2,
		8'h25, 8'h22, 8'h7C, 8'h3B, 8'h01, 8'h21, 8'h78, 8'h87,
		8'hD4, 8'h00, 8'h46, 8'h57, 8'h9F, 8'hD3, 8'h27, 8'h52,
		8'h4C, 8'h36, 8'h02, 8'hE7, 8'hA0, 8'hC4, 8'hC8, 8'h9E,
		8'hEA, 8'hBF, 8'h8A, 8'hD2, 8'h40, 8'hC7, 8'h38, 8'hB5,
		8'hA3, 8'hF7, 8'hF2, 8'hCE, 8'hF9, 8'h61, 8'h15, 8'hA1,
		8'hE0, 8'hAE, 8'h5D, 8'hA4, 8'h9B, 8'h34, 8'h1A, 8'h55,
		8'hAD, 8'h93, 8'h32, 8'h30, 8'hF5, 8'h8C, 8'hB1, 8'hE3,
		8'h1D, 8'hF6, 8'hE2, 8'h2E, 8'h82, 8'h66, 8'hCA, 8'h60,
		8'hC0, 8'h29, 8'h23, 8'hAB, 8'h0D, 8'h53, 8'h4E, 8'h6F,
		8'hD5, 8'hDB, 8'h37, 8'h45, 8'hDE, 8'hFD, 8'h8E, 8'h2F,
		8'h03, 8'hFF, 8'h6A, 8'h72, 8'h6D, 8'h6C, 8'h5B, 8'h51,
		8'h8D, 8'h1B, 8'hAF, 8'h92, 8'hBB, 8'hDD, 8'hBC, 8'h7F,
		8'h11, 8'hD9, 8'h5C, 8'h41, 8'h1F, 8'h10, 8'h5A, 8'hD8,
		8'h0A, 8'hC1, 8'h31, 8'h88, 8'hA5, 8'hCD, 8'h7B, 8'hBD,
		8'h2D, 8'h74, 8'hD0, 8'h12, 8'hB8, 8'hE5, 8'hB4, 8'hB0,
		8'h89, 8'h69, 8'h97, 8'h4A, 8'h0C, 8'h96, 8'h77, 8'h7E,
		8'h65, 8'hB9, 8'hF1, 8'h09, 8'hC5, 8'h6E, 8'hC6, 8'h84,
		8'h18, 8'hF0, 8'h7D, 8'hEC, 8'h3A, 8'hDC, 8'h4D, 8'h20,
		8'h79, 8'hEE, 8'h5F, 8'h3E, 8'hD7, 8'hCB, 8'h39, 8'h48
	};

	function automatic logic [31:0] tau(input logic [31:0] x);
		return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
	endfunction

	function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic logic [31:0] lin_data(input logic [31:0] x);
		return x ^ rotl(x, 2) ^ rotl(x, 10) ^ rotl(x, 18) ^ rotl(x, 24);
	endfunction

	function automatic logic [31:0] lin_key(input logic [31:0] x);
		return x ^ rotl(x, 13) ^ rotl(x, 23);
	endfunction

endpackage

>>> rtl/sm4_cfg.sv
module sm4_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sm4_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [63:0]                     cfg_data,
	output sm4_pkg::cfg_regs_t              regs
);
	import sm4_pkg::*;

	logic [63:0] key_high_q;
	logic [63:0] key_low_q;
	logic [63:0] iv_high_q;
	logic [63:0] iv_low_q;
	logic [2:0]  mode_q;
	logic        wr;

	assign cfg_ready = 1'b1;
	assign wr = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
			iv_high_q  <= '0;
			iv_low_q   <= '0;
			mode_q     <= '0;
		end else if (wr) begin
			unique case (cfg_index)
				REG_KEY_HIGH: key_high_q <= cfg_data;
				REG_KEY_LOW:  key_low_q  <= cfg_data;
				REG_IV_HIGH:  iv_high_q  <= cfg_data;
				REG_IV_LOW:   iv_low_q   <= cfg_data;
				REG_MODE:     mode_q     <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		regs.key_high = key_high_q;
		regs.key_low  = key_low_q;
		regs.iv_high  = iv_high_q;
		regs.iv_low   = iv_low_q;
		regs.mode     = mode_q;
		regs.key_wr   = wr && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW);
	end

endmodule

>>> rtl/sm4_rk_ram.sv
module sm4_rk_ram (
	input  logic             clk,
	input  sm4_pkg::rk_req_t req,
	output logic [31:0]      rdata
);
	import sm4_pkg::*;

	logic [31:0] mem [ROUNDS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[req.raddr];
	end

endmodule

>>> rtl/sm4_ctrl.sv
module sm4_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sm4_pkg::cfg_regs_t    cfg,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  sm4_pkg::in_item_t     in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output sm4_pkg::out_item_t    out_item,
	output sm4_pkg::rk_req_t      rk_req,
	input  logic [31:0]           rk_rdata
);
	import sm4_pkg::*;

	localparam logic [RK_AW-1:0] LAST = RK_AW'(ROUNDS - 1);

	sm4_state_t       state_q, state_d;
	logic [RK_AW-1:0] cnt_q;
	logic [RK_AW-1:0] ridx;
	logic             keys_ready_q;
	logic             out_valid_q;
	out_item_t        out_q;
	logic [2:0]       mode_q;
	logic             dec_q;
	logic [3:0][31:0] w_q;
	logic [3:0][31:0] k_q;
	logic [31:0]      ck_q;
	logic [127:0]     data_q;
	logic [127:0]     chain_q;

	logic             in_acc;
	logic             fin_fire;
	logic [127:0]     chain_eff;
	logic [127:0]     in_data;
	logic [127:0]     blk;
	logic [31:0]      key_x;
	logic [31:0]      rnd_x;
	logic [127:0]     core_out;
	logic [127:0]     result;
	logic [127:0]     chain_nxt;

	assign in_acc    = in_valid && in_ready;
	assign in_data   = {in_item.data_high, in_item.data_low};
	assign chain_eff = in_item.first ? {cfg.iv_high, cfg.iv_low} : chain_q;
	assign key_x     = lin_key(tau(k_q[1] ^ k_q[2] ^ k_q[3] ^ ck_q ^ CK_XOR)) ^ k_q[0];
	assign rnd_x     = lin_data(tau(w_q[1] ^ w_q[2] ^ w_q[3] ^ rk_rdata)) ^ w_q[0];
	assign core_out  = w_q;

	always_comb begin
		unique case (cfg.mode)
			MODE_CBC_ENC: blk = in_data ^ chain_eff;
			MODE_CTR:     blk = chain_eff;
			default:      blk = in_data;
		endcase
	end

	always_comb begin
		unique case (mode_q)
			MODE_CBC_ENC: begin
				result    = core_out;
				chain_nxt = core_out;
			end
			MODE_CBC_DEC: begin
				result    = core_out ^ chain_q;
				chain_nxt = data_q;
			end
			MODE_CTR: begin
				result    = core_out ^ data_q;
				chain_nxt = chain_q + 128'd1;
			end
			default: begin
				result    = core_out;
				chain_nxt = chain_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		fin_fire     = 1'b0;
		ridx         = '0;
		rk_req.we    = 1'b0;
		rk_req.waddr = cnt_q;
		rk_req.wdata = key_x;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = keys_ready_q ? ST_PREP : ST_EXPAND;
				end
			end
			ST_EXPAND: begin
				rk_req.we = 1'b1;
				if (cnt_q == LAST) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				state_d = ST_ROUND;
			end
			ST_ROUND: begin
				ridx = cnt_q + RK_AW'(1);
				if (cnt_q == LAST) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					fin_fire = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		rk_req.raddr = dec_q ? ~ridx : ridx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			keys_ready_q <= 1'b0;
			out_valid_q  <= 1'b0;
			chain_q      <= '0;
		end else begin
			cnt_q <= (state_q == ST_EXPAND || state_q == ST_ROUND) ? cnt_q + RK_AW'(1) : '0;
			if (cfg.key_wr) begin
				keys_ready_q <= 1'b0;
			end else if (state_q == ST_EXPAND && cnt_q == LAST) begin
				keys_ready_q <= 1'b1;
			end
			if (fin_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (in_acc) begin
				chain_q <= chain_eff;
			end else if (fin_fire) begin
				chain_q <= chain_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q <= cfg.mode;
			dec_q  <= (cfg.mode == MODE_ECB_DEC) || (cfg.mode == MODE_CBC_DEC);
			data_q <= in_data;
			w_q[0] <= blk[127:96];
			w_q[1] <= blk[95:64];
			w_q[2] <= blk[63:32];
			w_q[3] <= blk[31:0];
			k_q[0] <= cfg.key_high[63:32] ^ FK0;
			k_q[1] <= cfg.key_high[31:0] ^ FK1;
			k_q[2] <= cfg.key_low[63:32] ^ FK2;
			k_q[3] <= cfg.key_low[31:0] ^ FK3;
			ck_q   <= CK_INIT;
		end else if (state_q == ST_EXPAND) begin
			k_q  <= {key_x, k_q[3], k_q[2], k_q[1]};
			ck_q <= (ck_q + CK_STEP) & CK_MASK;
		end else if (state_q == ST_ROUND) begin
			w_q <= {rnd_x, w_q[3], w_q[2], w_q[1]};
		end
		if (fin_fire) begin
			out_q.result_high <= result[127:64];
			out_q.result_low  <= result[63:0];
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

>>> rtl/sm4_cipher_ecb_cbc_ctr.sv
// An accepted block runs IDLE, PREP, the rounds and FINISH, where its result is registered;
// round keys are expanded before PREP for the first block after reset or a key write.
// FINISH waits while the previous result is not yet taken; a new block is accepted only in IDLE;
// one round per cycle, each round key read from the round key RAM in the cycle before its round.
// Reset: arst_n clears config, chain/counter and the key-ready flag;
// the round key RAM is not cleared and is rebuilt before its first use.
module sm4_cipher_ecb_cbc_ctr (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sm4_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  sm4_pkg::in_item_t             in_item,
	output logic                          out_valid,
	input  logic                          out_ready,
	output sm4_pkg::out_item_t            out_item
);
	import sm4_pkg::*;

	cfg_regs_t   regs;
	rk_req_t     rk_req;
	logic [31:0] rk_rdata;

	sm4_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	sm4_rk_ram u_rk_ram (
		.clk   (clk),
		.req   (rk_req),
		.rdata (rk_rdata)
	);

	sm4_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (regs),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.rk_req    (rk_req),
		.rk_rdata  (rk_rdata)
	);

endmodule

>>> rtl/sm4_checker.sv
`include "sm4_cipher_ecb_cbc_ctr_defines.svh"

module sm4_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input sm4_pkg::out_item_t out_item
);
	import sm4_pkg::*;

	`SM4_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_item), "result request dropped or changed while stalled")
	`SM4_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "request accepted while busy")
	`SM4_ASSERT(a_busy_through_rounds, in_valid && in_ready |-> ##34 !in_ready, "request accepted before rounds finished")
	`SM4_ASSERT(a_result_after_work, $rose(out_valid) |-> $past(!in_ready), "result without preceding work")
	`SM4_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !out_valid, "result request right after reset")

endmodule

bind sm4_cipher_ecb_cbc_ctr sm4_checker u_sm4_checker (.*);
